// ===== rtl/swpd_pkg.sv =====
// Shared types and constants for the single-wire sensor pulse decoder.
// No dependencies; used by swpd_front, swpd_back and the top level.
package swpd_pkg;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_EDGE    = 2'd1,
    CMD_FINISH  = 2'd2,
    CMD_TIMEOUT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PULSE    = 2'd1,
    ST_CHECKSUM = 2'd2,
    ST_TIMEOUT  = 2'd3
  } status_t;

  localparam logic [6:0] PULSE_TOTAL = 7'd82;
  localparam logic [7:0] ACK0_MIN = 8'd40;
  localparam logic [7:0] ACK0_MAX = 8'd210;
  localparam logic [7:0] ACK1_MIN = 8'd60;
  localparam logic [7:0] ACK1_MAX = 8'd100;
  localparam logic [7:0] LOW_MIN  = 8'd35;
  localparam logic [7:0] LOW_MAX  = 8'd85;
  localparam logic [7:0] ZERO_MIN = 8'd10;
  localparam logic [7:0] ZERO_MAX = 8'd45;
  localparam logic [7:0] ONE_MIN  = 8'd55;
  localparam logic [7:0] ONE_MAX  = 8'd95;
  localparam logic [7:0] WIDTH_SAT = 8'hFF;
  localparam int unsigned BIT_COUNT = 40;

  // Classified operation handed from the front end to the decoder core.
  typedef struct packed {
    cmd_t        op;
    logic        has_result;
    logic [15:0] etime;
  } op_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] humidity;
    logic [15:0] temperature;
  } result_t;

endpackage

// ===== rtl/swpd_fifo.sv =====
// Two-entry register queue with full/empty flags.
// Generic; no package dependency.
module swpd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r;
  logic             do_wr, do_rd;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_r <= !wr_ptr_r;
      if (do_rd) rd_ptr_r <= !rd_ptr_r;
      case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slot_r[wr_ptr_r] <= wr_data;
  end

endmodule

// ===== rtl/swpd_front.sv =====
// Front end: accepts commands, classifies them and queues them for the core.
// Depends on swpd_pkg and swpd_fifo.
module swpd_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  logic [1:0]     in_cmd,
  input  logic [15:0]    in_edge_time,
  output swpd_pkg::op_t  op,
  output logic           op_valid,
  input  logic           op_pop
);

  swpd_pkg::op_t cls;
  logic          op_empty;

  always_comb begin
    cls.op    = swpd_pkg::cmd_t'(in_cmd);
    cls.etime = in_edge_time;
    case (cls.op)
      swpd_pkg::CMD_FINISH,
      swpd_pkg::CMD_TIMEOUT: cls.has_result = 1'b1;
      default:               cls.has_result = 1'b0;
    endcase
  end

  swpd_fifo #(.WIDTH($bits(swpd_pkg::op_t))) u_op_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (cls),
    .rd_en   (op_pop),
    .rd_data (op),
    .full    (full),
    .empty   (op_empty)
  );

  assign op_valid = !op_empty;

endmodule

// ===== rtl/swpd_back.sv =====
// Decoder core: pulse timing checks, bit assembly and checksum decode.
// Depends on swpd_pkg.
module swpd_back #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  swpd_pkg::op_t      op,
  input  logic               op_valid,
  output logic               op_pop,
  input  logic               res_full,
  output logic               res_push,
  output swpd_pkg::result_t  res
);

  localparam int BW = swpd_pkg::BIT_COUNT;

  logic [COUNTER_WIDTH-1:0] last_r, last_nxt;
  logic [6:0]               idx_r, idx_nxt;
  logic [7:0]               low_r, low_nxt;
  logic [BW-1:0]            bits_r, bits_nxt;
  logic                     err_r, err_nxt;

  logic [31:0]              now32, el32;
  logic [COUNTER_WIDTH-1:0] now, elapsed;
  logic [7:0]               w;
  logic                     fire, one_bit;
  logic [7:0]               b0, b1, b2, b3, b4, sum;

  assign fire     = op_valid && (!op.has_result || !res_full);
  assign op_pop   = fire;
  assign res_push = fire && op.has_result;

  assign now32   = {16'd0, op.etime};
  assign now     = now32[COUNTER_WIDTH-1:0];
  assign elapsed = now - last_r;
  assign el32    = 32'(elapsed);
  assign w       = (el32 > 32'd255) ? swpd_pkg::WIDTH_SAT : el32[7:0];

  assign b0  = bits_r[39:32];
  assign b1  = bits_r[31:24];
  assign b2  = bits_r[23:16];
  assign b3  = bits_r[15:8];
  assign b4  = bits_r[7:0];
  assign sum = b0 + b1 + b2 + b3;

  assign one_bit = (w >= swpd_pkg::ONE_MIN) && (w <= swpd_pkg::ONE_MAX);

  always_comb begin
    last_nxt = last_r;
    idx_nxt  = idx_r;
    low_nxt  = low_r;
    bits_nxt = bits_r;
    err_nxt  = err_r;
    res.status      = swpd_pkg::ST_OK;
    res.humidity    = 16'd0;
    res.temperature = 16'd0;
    case (op.op)
      swpd_pkg::CMD_START: begin
        last_nxt = now;
        idx_nxt  = 7'd0;
        low_nxt  = 8'd0;
        bits_nxt = '0;
        err_nxt  = 1'b0;
      end
      swpd_pkg::CMD_EDGE: begin
        if (idx_r < swpd_pkg::PULSE_TOTAL) begin
          if (idx_r == 7'd0) begin
            if (w < swpd_pkg::ACK0_MIN || w > swpd_pkg::ACK0_MAX) err_nxt = 1'b1;
          end else if (idx_r == 7'd1) begin
            if (w < swpd_pkg::ACK1_MIN || w > swpd_pkg::ACK1_MAX) err_nxt = 1'b1;
          end else if (!idx_r[0]) begin
            // low half of a data pair: hold until the high half arrives
            low_nxt = w;
          end else begin
            if (low_r < swpd_pkg::LOW_MIN || low_r > swpd_pkg::LOW_MAX) err_nxt = 1'b1;
            if (!one_bit && (w < swpd_pkg::ZERO_MIN || w > swpd_pkg::ZERO_MAX))
              err_nxt = 1'b1;
            bits_nxt = {bits_r[BW-2:0], one_bit};
          end
          last_nxt = now;
          idx_nxt  = idx_r + 7'd1;
        end
      end
      swpd_pkg::CMD_FINISH: begin
        if (idx_r < swpd_pkg::PULSE_TOTAL || err_r) begin
          res.status = swpd_pkg::ST_PULSE;
        end else if (sum != b4) begin
          res.status = swpd_pkg::ST_CHECKSUM;
        end else begin
          res.humidity    = {b0, b1};
          res.temperature = {b2, b3};
        end
        idx_nxt = swpd_pkg::PULSE_TOTAL;
      end
      default: begin
        res.status = swpd_pkg::ST_TIMEOUT;
        idx_nxt    = swpd_pkg::PULSE_TOTAL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      idx_r  <= swpd_pkg::PULSE_TOTAL;
      low_r  <= 8'd0;
      bits_r <= '0;
      err_r  <= 1'b0;
    end else if (fire) begin
      last_r <= last_nxt;
      idx_r  <= idx_nxt;
      low_r  <= low_nxt;
      bits_r <= bits_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

// ===== rtl/single_wire_sensor_pulse_decoder_unit.sv =====
// Single-wire sensor reply decoder, top level: front end, decoder core and
// result queue. Depends on swpd_pkg, swpd_front, swpd_back and swpd_fifo.
//
// Commands enter through a queue-style port (push/full) and results leave
// through one (empty/pop). One command is accepted every clock cycle while the
// command queue is not full; the core retires one command per cycle out of a
// two-entry command queue unless stalled, and pushes a result into the result
// queue when it retires a finish or timeout command. A two-entry result queue
// lets commands keep flowing while a result waits to be popped; only when it is
// full does a finish or timeout stall the core. Edge times are counter values
// of COUNTER_WIDTH bits (taken from the 16-bit edge_time field); pulse widths
// are measured modulo the counter range and saturate at 255 microseconds.
module single_wire_sensor_pulse_decoder_unit #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_edge_time,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_status,
  output logic [15:0] out_humidity,
  output logic [15:0] out_temperature
);

  swpd_pkg::op_t     op;
  logic              op_valid, op_pop;
  logic              res_full, res_push;
  swpd_pkg::result_t res, res_head;

  swpd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_cmd       (in_cmd),
    .in_edge_time (in_edge_time),
    .op           (op),
    .op_valid     (op_valid),
    .op_pop       (op_pop)
  );

  swpd_back #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .op_valid (op_valid),
    .op_pop   (op_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  swpd_fifo #(.WIDTH($bits(swpd_pkg::result_t))) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .rd_en   (pop),
    .rd_data (res_head),
    .full    (res_full),
    .empty   (empty)
  );

  assign out_status      = res_head.status;
  assign out_humidity    = res_head.humidity;
  assign out_temperature = res_head.temperature;

endmodule
